// File: sv/itp_pkg.sv
// Package for the infix-to-postfix converter.
// Holds character codes, error codes, the state type and the character
// classification functions. No dependencies.
`default_nettype none

package itp_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UPP_LO = 8'h41;
  localparam logic [7:0] CH_UPP_HI = 8'h5A;
  localparam logic [7:0] CH_LOW_LO = 8'h61;
  localparam logic [7:0] CH_LOW_HI = 8'h7A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic       CMD_CHAR  = 1'b0;
  localparam logic       CMD_END   = 1'b1;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WORK = 3'b010,
    ST_FILL = 3'b100
  } state_e;

  function automatic logic [1:0] rank_of(logic [7:0] c);
    logic [1:0] r;
    case (c) inside
      CH_PLUS, CH_MINUS: r = 2'd1;
      CH_STAR, CH_SLASH: r = 2'd2;
      CH_CARET:          r = 2'd3;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    logic s;
    case (c) inside
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: s = 1'b1;
      default:                                       s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) ||
           ((c >= CH_UPP_LO) && (c <= CH_UPP_HI)) ||
           ((c >= CH_LOW_LO) && (c <= CH_LOW_HI));
  endfunction

endpackage

`default_nettype wire

// File: sv/itp_if.sv
// Channel interfaces of the infix-to-postfix converter.
// Input channel carries command and character; output channel the result.
// Depends on nothing.
`default_nettype none

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink   (input valid, input cmd, input ch, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       last;
  logic       done_res;
  logic [1:0] error;

  modport source (output valid, output out_char, output has_char, output last,
                  output done_res, output error, input ready);
  modport sink   (input valid, input out_char, input has_char, input last,
                  input done_res, input error, output ready);
endinterface

`default_nettype wire

// File: sv/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter (shunting-yard).
// Uses itp_pkg, itp_in_if, itp_out_if and itp_stack_ram.
//
//   port    | dir | payload                                   | transfer
//   in_i    | in  | cmd, ch                                   | valid & ready
//   out_o   | out | out_char, has_char, last, done_res, error | valid & ready
//
// Each character is first taken into the input register, then acted on.
// A pop that leaves entries on the stack passes through ST_FILL, as the new
// top comes back from the registered stack memory read; dropping a matched '('
// does so too when entries remain. A popped operator waits a step for its last flag.
// Reset clears the stack count and the error; the stack memory is not cleared.
// The input stalls while an item is in work; a stalled output stalls the work.
`default_nettype none

module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  itp_in_if.sink    in_i,
  itp_out_if.source out_o
);

  localparam int Aw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int Cw = $clog2(STACK_DEPTH + 1);

  state_e         state_q, state_d;
  logic           cmd_q;
  logic [7:0]     ch_q;
  logic [Cw-1:0]  cnt_q, cnt_d;
  logic [7:0]     top_q, top_d;
  logic [1:0]     err_q, err_d;
  logic           pend_v_q, pend_v_d;
  logic [7:0]     pend_c_q, pend_c_d;
  logic           fin_q, fin_d;

  logic           ov_q;
  logic [7:0]     oc_q;
  logic           oh_q, ol_q, odn_q;
  logic [1:0]     oe_q;

  logic           emit;
  logic [7:0]     e_char;
  logic           e_has, e_last, e_done;
  logic [1:0]     e_err;

  logic           ram_we, ram_re;
  logic [Aw-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  logic           out_free;
  logic           cont;
  logic           cnt_ge2;
  logic           full;
  logic [Cw-1:0]  cnt_m1, cnt_m2;

  itp_stack_ram #(
    .Depth (STACK_DEPTH),
    .Aw    (Aw)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = ov_q;
  assign out_o.out_char = oc_q;
  assign out_o.has_char = oh_q;
  assign out_o.last     = ol_q;
  assign out_o.done_res = odn_q;
  assign out_o.error    = oe_q;

  assign out_free = !ov_q || out_o.ready;
  assign cnt_m1   = cnt_q - Cw'(1);
  assign cnt_m2   = cnt_q - Cw'(2);
  assign cnt_ge2  = (cnt_q >= Cw'(2));
  assign full     = (cnt_q >= Cw'(STACK_DEPTH));

  always_comb begin
    if (cmd_q == CMD_END) begin
      cont = (cnt_q != '0);
    end else if (ch_q == CH_RPAREN) begin
      cont = (cnt_q != '0) && (top_q != CH_LPAREN);
    end else begin
      cont = (cnt_q != '0) && (rank_of(ch_q) <= rank_of(top_q));
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    top_d     = top_q;
    err_d     = err_q;
    pend_v_d  = pend_v_q;
    pend_c_d  = pend_c_q;
    fin_d     = fin_q;
    emit      = 1'b0;
    e_char    = CH_NUL;
    e_has     = 1'b0;
    e_last    = 1'b0;
    e_done    = 1'b0;
    e_err     = ERR_NONE;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[Aw-1:0];
    ram_wdata = ch_q;
    ram_re    = 1'b0;
    ram_raddr = cnt_m2[Aw-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        if (cmd_q == CMD_END) begin
          if (out_free) begin
            emit = 1'b1;
            if (cont) begin
              e_char = top_q;
              e_has  = 1'b1;
              cnt_d  = cnt_m1;
              if (cnt_ge2) begin
                ram_re  = 1'b1;
                state_d = ST_FILL;
              end
            end else begin
              e_last  = 1'b1;
              e_done  = 1'b1;
              e_err   = err_q;
              err_d   = ERR_NONE;
              cnt_d   = '0;
              state_d = ST_IDLE;
            end
          end
        end else if ((err_q != ERR_NONE) || is_space(ch_q)) begin
          state_d = ST_IDLE;
        end else if (is_alnum(ch_q)) begin
          if (out_free) begin
            emit    = 1'b1;
            e_char  = ch_q;
            e_has   = 1'b1;
            e_last  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if ((ch_q == CH_LPAREN) || !cont) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              emit   = 1'b1;
              e_char = pend_c_q;
              e_has  = 1'b1;
              e_last = 1'b1;
            end
            pend_v_d = 1'b0;
            state_d  = ST_IDLE;
            if (ch_q == CH_RPAREN) begin
              if (cnt_q == '0) begin
                err_d = ERR_UNMATCHED;
              end else begin
                cnt_d = cnt_m1;
                if (cnt_ge2) begin
                  ram_re  = 1'b1;
                  fin_d   = 1'b1;
                  state_d = ST_FILL;
                end
              end
            end else if (full) begin
              err_d = ERR_OVERFLOW;
            end else begin
              ram_we = 1'b1;
              top_d  = ch_q;
              cnt_d  = cnt_q + Cw'(1);
            end
          end
        end else begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              emit   = 1'b1;
              e_char = pend_c_q;
              e_has  = 1'b1;
            end
            pend_v_d = 1'b1;
            pend_c_d = top_q;
            cnt_d    = cnt_m1;
            if (cnt_ge2) begin
              ram_re  = 1'b1;
              state_d = ST_FILL;
            end
          end
        end
      end
      ST_FILL: begin
        top_d   = ram_rdata;
        fin_d   = 1'b0;
        state_d = fin_q ? ST_IDLE : ST_WORK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      err_q    <= ERR_NONE;
      pend_v_q <= 1'b0;
      fin_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
      pend_v_q <= pend_v_d;
      fin_q    <= fin_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    pend_c_q <= pend_c_d;
    if (in_i.valid && in_i.ready) begin
      cmd_q <= in_i.cmd;
      ch_q  <= in_i.ch;
    end
    if (emit) begin
      oc_q  <= e_char;
      oh_q  <= e_has;
      ol_q  <= e_last;
      odn_q <= e_done;
      oe_q  <= e_err;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Cw'(STACK_DEPTH))
    else $error("stack count above depth");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !pend_v_q)
    else $error("held operator left behind at item end");

  a_fill_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |=> (state_q != ST_FILL))
    else $error("stack refill lasted more than one cycle");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && odn_q) |-> (ol_q && !oh_q))
    else $error("done result without last flag");

endmodule

`default_nettype wire

// File: sv/itp_stack_ram.sv
// Operator stack storage: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module itp_stack_ram #(
  parameter int Depth = 32,
  parameter int Aw    = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [Aw-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
